// ===== rtl/median_filter_3x3_defines.svh =====
// Assertion macros for the 3x3 median filter.
// Used by the port monitor that is bound to the top level; needs clk and rst in scope.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Checked property, switched off while reset is high.
`define MF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define MF3_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared constants and types for the 3x3 median filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  // Default parameter values.
  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  // Fixed field widths.
  localparam int ROW_W      = 12;
  localparam int OUT_COL_W  = 10;
  localparam int CFG_COLS_W = 11;
  localparam int CFG_ROWS_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_USER_W = 2;

  // Frame geometry limits.
  localparam int MIN_DIM  = 3;
  localparam int MAX_ROWS = 4095;

  // Reset geometry.
  localparam logic [CFG_COLS_W-1:0] RST_FRAME_COLS = CFG_COLS_W'(640);
  localparam logic [CFG_ROWS_W-1:0] RST_FRAME_ROWS = CFG_ROWS_W'(480);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COLS = 1'b0,
    REG_FRAME_ROWS = 1'b1
  } cfg_reg_t;

  // Output tuser bit positions.
  localparam int USER_FILTERED = 0;
  localparam int USER_END_RUN  = 1;

endpackage

`default_nettype wire

// ===== rtl/mf3_line_buf.sv =====
// Two line stores holding the previous two rows of the plane.
// Depends on mf3_pkg. One read and one write per store and cycle, read data registered.
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_buf
  import mf3_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int ADDR_W    = $clog2(MAX_COLS)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_W-1:0]     addr,
  input  wire logic [PIXEL_BITS-1:0] pix,
  output logic      [PIXEL_BITS-1:0] old_pix,
  output logic      [PIXEL_BITS-1:0] rec_pix
);

  logic [PIXEL_BITS-1:0] older_line  [MAX_COLS];
  logic [PIXEL_BITS-1:0] recent_line [MAX_COLS];

  logic [PIXEL_BITS-1:0] rd_old;
  logic [PIXEL_BITS-1:0] rd_rec;
  logic [PIXEL_BITS-1:0] fwd_data;
  logic                  fwd;
  logic                  wr_pend;
  logic [ADDR_W-1:0]     wr_addr;

  // Recent row: read the old entry and store the new pixel at the same edge.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rec            <= recent_line[addr];
      recent_line[addr] <= pix;
    end
  end

  // Older row: read on each transfer, and at the next edge store what the
  // recent row held at that column.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_old   <= older_line[addr];
      fwd_data <= rd_rec;
      wr_addr  <= addr;
    end
    if (wr_pend) begin
      older_line[wr_addr] <= rd_rec;
    end
  end

  // The older write lands at the next edge; a read of the same column at that
  // edge takes the value being written instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      fwd     <= 1'b0;
    end else begin
      wr_pend <= rd_en;
      if (rd_en) begin
        fwd <= wr_pend && (addr == wr_addr);
      end
    end
  end

  assign old_pix = fwd ? fwd_data : rd_old;
  assign rec_pix = rd_rec;

endmodule

`default_nettype wire

// ===== rtl/mf3_median9.sv =====
// Median of nine pixels by a fixed compare-exchange network.
// Depends on mf3_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module mf3_median9
  import mf3_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic [PIXEL_BITS-1:0] win [9],
  output logic      [PIXEL_BITS-1:0] median
);

  // Returns {max, min} of two pixels.
  function automatic logic [2*PIXEL_BITS-1:0] sort2(input logic [PIXEL_BITS-1:0] a,
                                                    input logic [PIXEL_BITS-1:0] b);
    if (a > b) begin
      return {a, b};
    end
    return {b, a};
  endfunction

  logic [PIXEL_BITS-1:0] p [9];

  // Nineteen exchanges leave the median in the center slot.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = win[i];
    end
    {p[2], p[1]} = sort2(p[1], p[2]);
    {p[5], p[4]} = sort2(p[4], p[5]);
    {p[8], p[7]} = sort2(p[7], p[8]);
    {p[1], p[0]} = sort2(p[0], p[1]);
    {p[4], p[3]} = sort2(p[3], p[4]);
    {p[7], p[6]} = sort2(p[6], p[7]);
    {p[2], p[1]} = sort2(p[1], p[2]);
    {p[5], p[4]} = sort2(p[4], p[5]);
    {p[8], p[7]} = sort2(p[7], p[8]);
    {p[3], p[0]} = sort2(p[0], p[3]);
    {p[8], p[5]} = sort2(p[5], p[8]);
    {p[7], p[4]} = sort2(p[4], p[7]);
    {p[6], p[3]} = sort2(p[3], p[6]);
    {p[4], p[1]} = sort2(p[1], p[4]);
    {p[5], p[2]} = sort2(p[2], p[5]);
    {p[7], p[4]} = sort2(p[4], p[7]);
    {p[2], p[4]} = sort2(p[4], p[2]);
    {p[4], p[6]} = sort2(p[6], p[4]);
    {p[2], p[4]} = sort2(p[4], p[2]);
    median = p[4];
  end

endmodule

`default_nettype wire

// ===== rtl/median_filter_3x3.sv =====
// 3x3 median filter: top level with position counters, window and result queue.
// Depends on mf3_pkg, mf3_line_buf and mf3_median9.
//
// Usage:
// Pixels of one plane enter in raster order on the s_ stream, one per
// transfer; s_tuser high marks the first pixel of a plane. Results leave on
// the m_ stream with their row and column. Interior pixels carry the median
// of their 3x3 neighborhood, border pixels pass through unchanged.
// Geometry is set through cfg_we/cfg_addr/cfg_wdata while the block is idle.
// A result is registered in the input stage and then in the result queue.
// Throughput: one pixel per clock while each input causes at most one result
// and the receiver is ready; an input that causes k results (up to four, at
// row and frame ends) holds the output until all are sent; the input waits too.
// The input stage, line store read and result queue form a two-deep
// pipeline, so a new pixel is taken while a result waits for the receiver.
// A stalled receiver stops the result queue; the input side keeps going
// until the input register is full, then drops s_tready.
// Reset clears the counters to row 0, column 0, the window to zero, empties
// the pipeline and restores 640 columns by 480 rows; the line stores keep
// their contents and are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((PIXEL_BITS + ROW_W + OUT_COL_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input pixel stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,   // in_pixel
  input  wire logic                  s_tuser,   // start_of_frame
  // Result stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic      [OUT_W-1:0]      m_tdata,   // out_pixel, out_row, out_col
  output logic      [OUT_USER_W-1:0] m_tuser,   // was_filtered, end_of_run
  output logic                       m_tlast    // end_of_frame
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);

  typedef enum logic [1:0] {
    SLOT_DIAG   = 2'd0,
    SLOT_ABOVE  = 2'd1,
    SLOT_LEFT   = 2'd2,
    SLOT_CORNER = 2'd3
  } slot_t;

  // Configuration registers.
  logic [CFG_COLS_W-1:0] frame_cols;
  logic [CFG_ROWS_W-1:0] frame_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols <= RST_FRAME_COLS;
      frame_rows <= RST_FRAME_ROWS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_COLS: frame_cols <= cfg_wdata[CFG_COLS_W-1:0];
        REG_FRAME_ROWS: frame_rows <= cfg_wdata[CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry, held within the supported range.
  logic [CNT_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;
  logic [CW-1:0]    col_last;
  logic [ROW_W-1:0] row_last;

  always_comb begin
    if (32'(frame_cols) > MAX_COLS) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else if (32'(frame_cols) < MIN_DIM) begin
      cols_eff = CNT_W'(MIN_DIM);
    end else begin
      cols_eff = CNT_W'(frame_cols);
    end
    if (32'(frame_rows) < MIN_DIM) begin
      rows_eff = ROW_W'(MIN_DIM);
    end else begin
      rows_eff = frame_rows;
    end
    col_last = CW'(cols_eff - CNT_W'(1));
    row_last = rows_eff - ROW_W'(1);
  end

  // Input handshake and pipeline control.
  logic a_valid;
  logic a_adv;
  logic in_xfer;
  logic out_xfer;
  logic [3:0] r_mask;
  logic [3:0] low_bit;
  logic [3:0] mask_left;

  assign low_bit   = r_mask & (~r_mask + 4'd1);
  assign mask_left = r_mask & ~low_bit;
  assign m_tvalid  = |r_mask;
  assign out_xfer  = m_tvalid && m_tready;
  assign a_adv     = a_valid && (!m_tvalid || (out_xfer && (mask_left == 4'd0)));
  assign s_tready  = !a_valid || a_adv;
  assign in_xfer   = s_tvalid && s_tready;

  // Position of the incoming pixel.
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] rc;
  logic [CW-1:0]    cc;
  logic [ROW_W-1:0] in_r;
  logic [CW-1:0]    in_c;
  logic             in_last_col;
  logic             in_last_row;

  always_comb begin
    rc          = s_tuser ? '0 : row_count;
    cc          = s_tuser ? '0 : col_count;
    in_r        = (rc > row_last) ? row_last : rc;
    in_c        = (cc > col_last) ? col_last : cc;
    in_last_col = (in_c == col_last);
    in_last_row = (in_r == row_last);
  end

  // Counters advance on each input transfer and wrap at the frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_xfer) begin
      if (in_last_col) begin
        col_count <= '0;
        row_count <= in_last_row ? '0 : in_r + ROW_W'(1);
      end else begin
        col_count <= in_c + CW'(1);
        row_count <= in_r;
      end
    end
  end

  // Input stage register.
  logic [PIXEL_BITS-1:0] a_pix;
  logic [ROW_W-1:0]      a_r;
  logic [CW-1:0]         a_c;
  logic                  a_r1;
  logic                  a_c1;
  logic                  a_inner;
  logic                  a_last_col;
  logic                  a_last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_xfer) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_pix      <= s_tdata[PIXEL_BITS-1:0];
      a_r        <= in_r;
      a_c        <= in_c;
      a_r1       <= (in_r != '0);
      a_c1       <= (in_c != '0);
      a_inner    <= (in_r > ROW_W'(1)) && (in_c > CW'(1));
      a_last_col <= in_last_col;
      a_last_row <= in_last_row;
    end
  end

  // Line stores, read on the input transfer.
  logic [PIXEL_BITS-1:0] lb_old;
  logic [PIXEL_BITS-1:0] lb_rec;

  mf3_line_buf #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .addr    (in_c),
    .pix     (s_tdata[PIXEL_BITS-1:0]),
    .old_pix (lb_old),
    .rec_pix (lb_rec)
  );

  // Window shifts left and takes the new column: rows r-2, r-1, r.
  logic [PIXEL_BITS-1:0] win      [9];
  logic [PIXEL_BITS-1:0] win_next [9];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3]     = win[k*3 + 1];
      win_next[k*3 + 1] = win[k*3 + 2];
    end
    win_next[2] = lb_old;
    win_next[5] = lb_rec;
    win_next[8] = a_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (a_adv) begin
      win <= win_next;
    end
  end

  logic [PIXEL_BITS-1:0] med;

  mf3_median9 #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median9 (
    .win    (win_next),
    .median (med)
  );

  // Result queue: up to four results of one input, sent lowest slot first.
  logic [PIXEL_BITS-1:0] r_pix [4];
  logic [ROW_W-1:0]      r_row;
  logic [ROW_W-1:0]      r_row_m1;
  logic [CW-1:0]         r_col;
  logic [CW-1:0]         r_col_m1;
  logic                  r_filt;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_mask <= '0;
    end else if (a_adv) begin
      r_mask <= {a_last_row && a_last_col, a_last_row && a_c1,
                 a_r1 && a_last_col, a_r1 && a_c1};
    end else if (out_xfer) begin
      r_mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      r_pix[SLOT_DIAG]   <= a_inner ? med : win_next[4];
      r_pix[SLOT_ABOVE]  <= win_next[5];
      r_pix[SLOT_LEFT]   <= win_next[7];
      r_pix[SLOT_CORNER] <= a_pix;
      r_row              <= a_r;
      r_row_m1           <= a_r - ROW_W'(1);
      r_col              <= a_c;
      r_col_m1           <= a_c - CW'(1);
      r_filt             <= a_inner;
    end
  end

  // Output selection from the lowest pending slot.
  slot_t                      sel;
  logic [ROW_W-1:0]           o_row;
  logic [CW-1:0]              o_col;
  logic [CW+OUT_COL_W-1:0]    o_col_ext;

  always_comb begin
    unique case (low_bit)
      4'b0010: sel = SLOT_ABOVE;
      4'b0100: sel = SLOT_LEFT;
      4'b1000: sel = SLOT_CORNER;
      default: sel = SLOT_DIAG;
    endcase
    o_row     = ((sel == SLOT_DIAG) || (sel == SLOT_ABOVE)) ? r_row_m1 : r_row;
    o_col     = ((sel == SLOT_DIAG) || (sel == SLOT_LEFT)) ? r_col_m1 : r_col;
    o_col_ext = {{OUT_COL_W{1'b0}}, o_col};
  end

  assign m_tdata = OUT_W'({o_col_ext[OUT_COL_W-1:0], o_row, r_pix[sel]});
  assign m_tuser[USER_FILTERED] = (sel == SLOT_DIAG) && r_filt;
  assign m_tuser[USER_END_RUN]  = (mask_left == 4'd0);
  assign m_tlast = (sel == SLOT_CORNER);

endmodule

`default_nettype wire

// ===== rtl/mf3_assert.sv =====
// Port-level assertions for the 3x3 median filter, bound to the top level.
// Depends on mf3_pkg and median_filter_3x3_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "median_filter_3x3_defines.svh"

module mf3_assert
  import mf3_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((PIXEL_BITS + ROW_W + OUT_COL_W + 7) / 8) * 8
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic [IN_W-1:0]       s_tdata,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_W-1:0]      m_tdata,
  input wire logic [OUT_USER_W-1:0] m_tuser,
  input wire logic                  m_tlast
);

  localparam int ROW_LO = PIXEL_BITS;
  localparam int COL_LO = PIXEL_BITS + ROW_W;

  logic [ROW_W-1:0]     mon_row;
  logic [OUT_COL_W-1:0] mon_col;

  assign mon_row = m_tdata[ROW_LO +: ROW_W];
  assign mon_col = m_tdata[COL_LO +: OUT_COL_W];

  // A result held back by the receiver stays offered.
  `MF3_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // The final result of a plane also closes the run of its input.
  `MF3_ASSERT(a_eof_ends_run, m_tvalid && m_tlast |-> m_tuser[USER_END_RUN], "frame end without run end")

  // Only interior pixels carry a median; checked here for row 0 and column 0.
  `MF3_ASSERT(a_filt_interior, m_tvalid && m_tuser[USER_FILTERED] |-> (mon_row != '0) && (mon_col != '0), "median on border")

  // Reset empties the result queue.
  `MF3_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "result after reset")

endmodule

bind median_filter_3x3 mf3_assert #(.PIXEL_BITS(PIXEL_BITS)) u_mf3_assert (.*);

`default_nettype wire
